/* hw/rtl/btc_pkg.sv */
// ----------------------------------------------------------------------------
// btc_pkg
// Shared constants, types and tables for the byte to tape-code emitter.
// ----------------------------------------------------------------------------
package btc_pkg;

  // Largest divisor tried when splitting a difference into two factors
  localparam int MAX_DIVISOR = 16;
  localparam int DIV_W       = $clog2(MAX_DIVISOR + 1);

  // Fixed-point reciprocal precision for the divisibility test
  localparam int RECIP_W     = 12;
  localparam int DIFF_W      = 8;
  localparam int PROD_W      = DIFF_W + RECIP_W;
  localparam int CNT_W       = 7;
  localparam int SYM_W       = 7;

  // Symbols of the tape-machine code
  localparam logic [SYM_W-1:0] SYM_PLUS   = 7'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS  = 7'h2D;
  localparam logic [SYM_W-1:0] SYM_LEFT   = 7'h3C;
  localparam logic [SYM_W-1:0] SYM_RIGHT  = 7'h3E;
  localparam logic [SYM_W-1:0] SYM_OPEN   = 7'h5B;
  localparam logic [SYM_W-1:0] SYM_CLOSE  = 7'h5D;
  localparam logic [SYM_W-1:0] SYM_DOT    = 7'h2E;

  // Printed at end of input in message mode
  localparam logic [7:0] CHAR_NL        = 8'h0A;
  localparam logic [7:0] CHAR_PRINT_LO  = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI  = 8'h7E;

  // Result of the factor search
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] big;
    logic [CNT_W-1:0] small_f;
  } factor_t;

  // ceil(2^RECIP_W / i) for divisors 2..16
  function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] i);
    logic [RECIP_W-1:0] r;
    case (i)
      5'd2:    r = 12'd2048;
      5'd3:    r = 12'd1366;
      5'd4:    r = 12'd1024;
      5'd5:    r = 12'd820;
      5'd6:    r = 12'd683;
      5'd7:    r = 12'd586;
      5'd8:    r = 12'd512;
      5'd9:    r = 12'd456;
      5'd10:   r = 12'd410;
      5'd11:   r = 12'd373;
      5'd12:   r = 12'd342;
      5'd13:   r = 12'd316;
      5'd14:   r = 12'd293;
      5'd15:   r = 12'd274;
      5'd16:   r = 12'd256;
      default: r = 12'hFFF;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/btc_factor_unit.sv */
// ----------------------------------------------------------------------------
// btc_factor_unit
// Finds the largest divisor of a difference, from the top divisor down to 2,
// one divisor per cycle through a single multiply-and-compare unit.
// ----------------------------------------------------------------------------
module btc_factor_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [btc_pkg::DIFF_W-1:0]    diff,
  output logic                          busy,
  output btc_pkg::factor_t              res
);
  import btc_pkg::*;

  logic                busy_r;
  logic [DIV_W-1:0]    div_r;
  logic [DIFF_W-1:0]   diff_r;
  logic                done_r;
  logic [CNT_W-1:0]    big_r;
  logic [CNT_W-1:0]    small_r;

  logic [RECIP_W-1:0]  rc;
  logic [PROD_W-1:0]   prod;
  logic                hit;
  logic                last_try;
  logic [DIFF_W-1:0]   d1;
  logic [DIFF_W-1:0]   d2;
  logic [DIFF_W-1:0]   big_w;
  logic [DIFF_W-1:0]   small_w;

  // Divisibility test: frac(diff * ceil(2^N/i)) < ceil(2^N/i) iff i divides diff
  always_comb begin
    rc       = recip(div_r);
    prod     = PROD_W'(diff_r) * PROD_W'(rc);
    hit      = prod[RECIP_W-1:0] < rc;
    last_try = (div_r == DIV_W'(2));
    d1       = hit ? DIFF_W'(div_r) : DIFF_W'(1);
    d2       = hit ? prod[PROD_W-1:RECIP_W] : diff_r;
    big_w    = (d1 > d2) ? d1 : d2;
    small_w  = (d1 > d2) ? d2 : d1;
  end

  // Step the divisor down until a hit or the last divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      div_r  <= DIV_W'(MAX_DIVISOR);
      diff_r <= diff;
    end else if (busy_r) begin
      if (hit || last_try) begin
        busy_r  <= 1'b0;
        done_r  <= 1'b1;
        big_r   <= big_w[CNT_W-1:0];
        small_r <= small_w[CNT_W-1:0];
      end else begin
        done_r <= 1'b0;
        div_r  <= div_r - DIV_W'(1);
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign busy        = busy_r;
  assign res.done    = done_r;
  assign res.big     = big_r;
  assign res.small_f = small_r;

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (div_r >= DIV_W'(2)) && (div_r <= DIV_W'(MAX_DIVISOR)))
    else $error("divisor out of range during search");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("search started while busy");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (small_r <= big_r) && (small_r != '0))
    else $error("factor pair out of order");

endmodule

/* hw/rtl/byte_to_tape_code_emitter.sv */
// ----------------------------------------------------------------------------
// byte_to_tape_code_emitter
// Encodes each byte as run items of tape-machine code that step a cell from
// the previously printed byte to the new one, then print it.
// ----------------------------------------------------------------------------
// Operation: a changed byte tries 1 to 15 divisors, one per cycle through the
//   shared multiply-compare unit, then hands the factors over and emits one run
//   item per cycle while out_tready allows: 2 items for a plain run, 10 for a loop.
// Input: a new byte is taken only after the previous byte's print item has been
//   loaded into the output register; a repeated byte emits only the print
//   item, and dropped bytes and a plain end of input emit nothing.
// Reset: synchronous; previous byte and message mode clear to 0.
// ----------------------------------------------------------------------------
module byte_to_tape_code_emitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // [0] message_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] in_byte
  input  logic        in_tuser,      // [0] op (1 = end of input)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [6:0] symbol, [13:7] repeat_count, [15:14] zero
  output logic        out_tlast      // last_of_run
);
  import btc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_EMIT} state_t;

  typedef enum logic [3:0] {
    STEP_MOVE_R, STEP_SET, STEP_OPEN, STEP_MOVE_L, STEP_DIR,
    STEP_BACK_R, STEP_DEC, STEP_CLOSE, STEP_RETURN, STEP_DOT
  } step_t;

  state_t            state_r, state_nxt;
  step_t             step_r, step_nxt;
  logic              mode_r;
  logic [7:0]        prev_r, prev_nxt;
  logic [SYM_W-1:0]  dir_r, dir_nxt;
  logic [CNT_W-1:0]  big_r, big_nxt;
  logic [CNT_W-1:0]  small_r, small_nxt;
  logic              plain_r, plain_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  out_sym_r, out_sym_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              is_eoi;
  logic              printable;
  logic              encode;
  logic [7:0]        target;
  logic [7:0]        up;
  logic [7:0]        down;
  logic              fu_start;
  logic [DIFF_W-1:0] fu_diff;
  logic              fu_busy;
  factor_t           fu_res;
  logic [SYM_W-1:0]  step_sym;
  logic [CNT_W-1:0]  step_cnt;

  btc_factor_unit u_factor (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fu_start),
    .diff  (fu_diff),
    .busy  (fu_busy),
    .res   (fu_res)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Classify the input and take both differences mod 256
  always_comb begin
    is_eoi    = in_tuser;
    printable = (in_tdata >= CHAR_PRINT_LO) && (in_tdata <= CHAR_PRINT_HI);
    encode    = is_eoi ? mode_r : (!mode_r || printable);
    target    = is_eoi ? CHAR_NL : in_tdata;
    up        = target - prev_r;
    down      = prev_r - target;
    fu_diff   = (up < down) ? up : down;
  end

  // Map the current step to its run item
  always_comb begin
    step_cnt = CNT_W'(1);
    unique case (step_r)
      STEP_MOVE_R: step_sym = SYM_RIGHT;
      STEP_SET: begin
        step_sym = SYM_PLUS;
        step_cnt = big_r;
      end
      STEP_OPEN:   step_sym = SYM_OPEN;
      STEP_MOVE_L: step_sym = SYM_LEFT;
      STEP_DIR: begin
        step_sym = dir_r;
        step_cnt = small_r;
      end
      STEP_BACK_R: step_sym = SYM_RIGHT;
      STEP_DEC:    step_sym = SYM_MINUS;
      STEP_CLOSE:  step_sym = SYM_CLOSE;
      STEP_RETURN: step_sym = SYM_LEFT;
      STEP_DOT:    step_sym = SYM_DOT;
      default:     step_sym = SYM_DOT;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    prev_nxt      = prev_r;
    dir_nxt       = dir_r;
    big_nxt       = big_r;
    small_nxt     = small_r;
    plain_nxt     = plain_r;
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    fu_start      = 1'b0;

    // Drop the output item once transferred
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && encode) begin
          prev_nxt = target;
          if (target == prev_r) begin
            step_nxt  = STEP_DOT;
            state_nxt = ST_EMIT;
          end else begin
            dir_nxt   = (up < down) ? SYM_PLUS : SYM_MINUS;
            fu_start  = 1'b1;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (fu_res.done) begin
          big_nxt   = fu_res.big;
          plain_nxt = (fu_res.small_f == CNT_W'(1));
          small_nxt = (fu_res.small_f == CNT_W'(1)) ? fu_res.big : fu_res.small_f;
          step_nxt  = (fu_res.small_f == CNT_W'(1)) ? STEP_DIR : STEP_MOVE_R;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = step_sym;
          out_cnt_nxt   = step_cnt;
          out_last_nxt  = (step_r == STEP_DOT);
          if (step_r == STEP_DOT) begin
            state_nxt = ST_IDLE;
          end else if (plain_r && step_r == STEP_DIR) begin
            step_nxt = STEP_DOT;
          end else begin
            step_nxt = step_t'(step_r + 4'd1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state, configuration and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_DOT;
      mode_r      <= 1'b0;
      prev_r      <= '0;
      plain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      prev_r      <= prev_nxt;
      plain_r     <= plain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
    dir_r      <= dir_nxt;
    big_r      <= big_nxt;
    small_r    <= small_nxt;
    out_sym_r  <= out_sym_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_sym_r};
  assign out_tlast  = out_last_r;

  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    fu_res.done |-> (state_r == ST_SEARCH))
    else $error("factor result outside search");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) && !fu_res.done |-> fu_busy)
    else $error("search waiting on an idle factor unit");

  a_last_is_dot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> (out_sym_r == SYM_DOT))
    else $error("end of run on a symbol other than print");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (step_r <= STEP_DOT))
    else $error("step index past print");

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives bytes and end-of-input marks into the tape-code emitter under
// changing back-pressure and message-mode settings, predicts every run item
// from its own model of the cell value, and compares each output transfer.
// ----------------------------------------------------------------------------
module testbench;
  import btc_pkg::*;

  localparam logic OP_DATA      = 1'b0;
  localparam logic OP_END       = 1'b1;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   PHASE_ITEMS  = 65;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic [CNT_W-1:0] count;
    logic             last;
  } run_item_t;

  // Model of the cell value and the run items still owed by the block
  class run_item_tracker;
    logic [7:0] cell_value;
    logic       message_mode;
    run_item_t  pending_runs[$];
    int         errors;

    function new();
      cell_value   = 8'h00;
      message_mode = 1'b0;
      errors       = 0;
    endfunction

    function void push_run(logic [SYM_W-1:0] sym, int cnt, logic last);
      run_item_t r;
      r.symbol = sym;
      r.count  = cnt[CNT_W-1:0];
      r.last   = last;
      pending_runs.push_back(r);
    endfunction

    function int largest_factor(int d);
      for (int i = MAX_DIVISOR; i >= 2; i--) begin
        if (d % i == 0) return i;
      end
      return 1;
    endfunction

    // Step the cell to the new byte, then print it
    function void encode(logic [7:0] nxt);
      logic [7:0]       up;
      logic [7:0]       down;
      logic [SYM_W-1:0] dir;
      int               diff;
      int               f1;
      int               f2;
      int               big_f;
      int               small_f;
      if (nxt != cell_value) begin
        up   = nxt - cell_value;
        down = cell_value - nxt;
        if (up < down) begin
          dir  = SYM_PLUS;
          diff = int'(up);
        end else begin
          dir  = SYM_MINUS;
          diff = int'(down);
        end
        f1      = largest_factor(diff);
        f2      = diff / f1;
        big_f   = (f1 > f2) ? f1 : f2;
        small_f = (f1 > f2) ? f2 : f1;
        if (small_f == 1) begin
          push_run(dir, big_f, 1'b0);
        end else begin
          push_run(SYM_RIGHT, 1, 1'b0);
          push_run(SYM_PLUS, big_f, 1'b0);
          push_run(SYM_OPEN, 1, 1'b0);
          push_run(SYM_LEFT, 1, 1'b0);
          push_run(dir, small_f, 1'b0);
          push_run(SYM_RIGHT, 1, 1'b0);
          push_run(SYM_MINUS, 1, 1'b0);
          push_run(SYM_CLOSE, 1, 1'b0);
          push_run(SYM_LEFT, 1, 1'b0);
        end
      end
      push_run(SYM_DOT, 1, 1'b1);
      cell_value = nxt;
    endfunction

    // Note one accepted input transfer
    function void note_byte(logic op, logic [7:0] b);
      if (op == OP_DATA) begin
        if (message_mode && (b < CHAR_PRINT_LO || b > CHAR_PRINT_HI)) return;
        encode(b);
      end else if (message_mode) begin
        encode(CHAR_NL);
      end
    endfunction

    // Compare one output transfer with the oldest owed run item
    function void check_run_item(logic [15:0] data, logic last);
      run_item_t want;
      if (pending_runs.size() == 0) begin
        $error("unexpected run item: tdata %0h, tlast %0b", data, last);
        errors++;
        return;
      end
      want = pending_runs.pop_front();
      if (data[6:0] !== want.symbol) begin
        $error("symbol: expected %0h, got %0h", want.symbol, data[6:0]);
        errors++;
      end
      if (data[13:7] !== want.count) begin
        $error("repeat_count: expected %0d, got %0d", want.count, data[13:7]);
        errors++;
      end
      if (data[15:14] !== 2'b00) begin
        $error("pad: expected 0, got %0h", data[15:14]);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  int              cycle_count;
  logic [7:0]      last_printed   = 8'h00;
  run_item_tracker tracker;

  byte_to_tape_code_emitter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the output side at random
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watch both channels; inputs are noted before outputs are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_byte(in_tuser, in_tdata);
      if (out_tvalid && out_tready) tracker.check_run_item(out_tdata, out_tlast);
    end
  end

  // End a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[byte_to_tape_code_emitter] ERROR");
    $finish;
  end

  // Offer one item, with random idle cycles first, and hold it until transfer
  task automatic send_item(input logic op, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tuser  = 1'($urandom_range(1));
      in_tdata  = 8'($urandom_range(255));
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
  endtask

  // Send an item and report whether it causes any output
  task automatic send_tracked(input logic op, input logic [7:0] b, output bit counted);
    if (op == OP_DATA) begin
      counted = !(tracker.message_mode && (b < CHAR_PRINT_LO || b > CHAR_PRINT_HI));
      if (counted) last_printed = b;
    end else begin
      counted = tracker.message_mode;
      if (counted) last_printed = CHAR_NL;
    end
    send_item(op, b);
  endtask

  // Release the input and wait until every owed run item has left
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = 1'($urandom_range(1));
    tracker.message_mode = v;
  endtask

  // Mostly printable text in message mode, with drops, end marks and repeats
  task automatic random_item(output bit counted);
    int         pick;
    logic       op;
    logic [7:0] b;
    pick = $urandom_range(99);
    op   = OP_DATA;
    if (tracker.message_mode) begin
      if (pick < 65) begin
        b = 8'($urandom_range(CHAR_PRINT_HI, CHAR_PRINT_LO));
      end else if (pick < 80) begin
        if ($urandom_range(1)) b = 8'($urandom_range(8'h1F, 8'h00));
        else b = 8'($urandom_range(8'hFF, 8'h7F));
      end else if (pick < 90) begin
        op = OP_END;
        b  = 8'($urandom_range(255));
      end else begin
        b = last_printed;
      end
    end else begin
      if (pick < 10) begin
        op = OP_END;
        b  = 8'($urandom_range(255));
      end else if (pick < 20) begin
        b = last_printed;
      end else begin
        b = 8'($urandom_range(255));
      end
    end
    send_tracked(op, b, counted);
  endtask

  initial begin
    bit counted;
    int done_items;
    tracker     = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = OP_DATA;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, message mode off: repeats, ties at 128, prime runs, loops
    write_mode(1'b0);
    send_tracked(OP_DATA, 8'h00, counted);
    send_tracked(OP_DATA, 8'hFF, counted);
    send_tracked(OP_DATA, 8'h7F, counted);
    send_tracked(OP_DATA, 8'h80, counted);
    send_tracked(OP_DATA, 8'h00, counted);
    send_tracked(OP_DATA, 8'h11, counted);
    send_tracked(OP_DATA, 8'h90, counted);
    send_tracked(OP_END,  8'hA5, counted);
    send_tracked(OP_DATA, 8'h90, counted);
    send_tracked(OP_DATA, 8'h0C, counted);
    send_tracked(OP_DATA, 8'h2C, counted);
    drain();

    // Directed, message mode on: printable edges, drops, newline at end
    write_mode(1'b1);
    send_tracked(OP_DATA, 8'h1F, counted);
    send_tracked(OP_DATA, 8'h20, counted);
    send_tracked(OP_DATA, 8'h7E, counted);
    send_tracked(OP_DATA, 8'h7F, counted);
    send_tracked(OP_DATA, 8'h00, counted);
    send_tracked(OP_DATA, 8'hFF, counted);
    send_tracked(OP_END,  8'h5A, counted);
    send_tracked(OP_DATA, 8'h0A, counted);
    send_tracked(OP_END,  8'hFF, counted);
    send_tracked(OP_DATA, 8'h41, counted);
    send_tracked(OP_DATA, 8'h41, counted);
    drain();

    // Random phases under different idle and stall pressure
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      write_mode(ph[0] ? 1'b0 : 1'b1);
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) done_items++;
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.pending_runs.size() == 0) begin
      $display("[byte_to_tape_code_emitter] OK");
    end else begin
      $display("[byte_to_tape_code_emitter] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/btc_pkg.sv
hw/rtl/btc_factor_unit.sv
hw/rtl/byte_to_tape_code_emitter.sv
verif/testbench.sv
